// ===== design/flc_pkg.sv =====
// shared constants and types for the full linear convolution block
package flc_pkg;

  localparam int TapsDefault = 32;
  localparam int ValueW      = 16;
  localparam int ProdW       = 2 * ValueW;
  localparam int TapIdxW     = 5;
  localparam int CfgW        = 6;
  localparam int ResultW     = 36;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CfgW-1:0] TapCountReset = CfgW'(1);

  // control shared by every cell of the chain
  typedef struct packed {
    logic mul_en;
    logic shift_en;
    logic flush_en;
  } cell_ctrl_t;

  // one word handed to the output stage
  typedef struct packed {
    logic valid;
    logic last;
  } emit_ctrl_t;

endpackage

// ===== design/flc_cell.sv =====
// one tap cell: kernel tap, registered product and pending partial sum
module flc_cell import flc_pkg::*; #(
  parameter int AccW = 37
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     tap_we_i,
  input  logic                     keep_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic signed [AccW-1:0]   p_next_i,
  input  logic signed [ProdW-1:0]  prod_next_i,
  output logic signed [AccW-1:0]   p_o,
  output logic signed [ProdW-1:0]  prod_o
);

  logic signed [ValueW-1:0] tap_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   p_q, p_d;

  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_q <= value_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= ProdW'(tap_q) * ProdW'(value_i);
    end
  end

  always_comb begin
    p_d = p_q;
    if (ctrl_i.shift_en) begin
      p_d = keep_i ? (p_next_i + AccW'(prod_next_i)) : '0;
    end else if (ctrl_i.flush_en) begin
      p_d = p_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= p_d;
    end
  end

  assign p_o    = p_q;
  assign prod_o = prod_q;

endmodule

// ===== design/flc_out.sv =====
// output stage: saturation, running peak and the result register
module flc_out import flc_pkg::*; #(
  parameter int AccW = 37
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  emit_ctrl_t                emit_i,
  input  logic signed [AccW-1:0]    emit_value_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ResultW-1:0] result_value_o,
  output logic [ResultW-1:0]        peak_magnitude_o,
  output logic                      last_result_o
);

  localparam logic signed [AccW-1:0] SumMax = AccW'({1'b0, {(ResultW-1){1'b1}}});
  localparam logic signed [AccW-1:0] SumMin = ~SumMax;

  logic                      valid_q;
  logic [ResultW-1:0]        peak_q;
  logic signed [ResultW-1:0] sat;
  logic [ResultW-1:0]        mag;
  logic [ResultW-1:0]        peak_new;
  logic signed [ResultW-1:0] result_q;
  logic [ResultW-1:0]        peak_out_q;
  logic                      last_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    if (emit_value_i > SumMax) begin
      sat = SumMax[ResultW-1:0];
    end else if (emit_value_i < SumMin) begin
      sat = SumMin[ResultW-1:0];
    end else begin
      sat = emit_value_i[ResultW-1:0];
    end
    // the most negative value maps to 2^35, which still fits unsigned
    mag      = sat[ResultW-1] ? (~sat + ResultW'(1)) : sat;
    peak_new = (mag > peak_q) ? mag : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      peak_q  <= '0;
    end else begin
      if (emit_i.valid) begin
        valid_q <= 1'b1;
        peak_q  <= emit_i.last ? '0 : peak_new;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      result_q   <= sat;
      peak_out_q <= peak_new;
      last_q     <= emit_i.last;
    end
  end

  assign out_valid_o      = valid_q;
  assign result_value_o   = result_q;
  assign peak_magnitude_o = peak_out_q;
  assign last_result_o    = last_q;

endmodule

// ===== design/full_linear_convolution.sv =====
// Full linear convolution with running output peak. A load word writes one kernel
// tap. A sample word is multiplied by the tap cells in the accept cycle, the chain
// adds and shifts in the next, and the output stage saturates and updates the peak
// once it is free. A last sample then adds one tail output per tap in use but one
// (tap_count is clamped to 1..MaxTaps), and the output stage takes one word per
// cycle while it is free. The block takes no new word until the current one has
// handed all its outputs to the output register, and it needs no clearing pass.
module full_linear_convolution import flc_pkg::*; #(
  parameter int MaxTaps = TapsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [TapIdxW-1:0]        tap_index_i,
  input  logic signed [ValueW-1:0]  value_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ResultW-1:0] result_value_o,
  output logic [ResultW-1:0]        peak_magnitude_o,
  output logic                      last_result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgW-1:0]           cfg_data_i
);

  localparam int AccRaw = ProdW + $clog2(MaxTaps);
  localparam int AccW   = (AccRaw > ResultW + 1) ? AccRaw : ResultW + 1;
  localparam int MW     = $clog2(MaxTaps + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CfgW-1:0]        tap_count_q;
  logic [MW-1:0]          m_now;
  logic [MW-1:0]          m_q, m_d;
  logic [MW-1:0]          cnt_q, cnt_d;
  logic                   last_q, last_d;
  logic signed [AccW-1:0] y_q, y_d;

  logic                   in_acc;
  cell_ctrl_t             ctrl;
  emit_ctrl_t             emit;
  logic signed [AccW-1:0] emit_value;
  logic                   free;
  logic [MaxTaps-1:0]     tap_we;
  logic [MaxTaps-1:0]     keep;

  logic signed [AccW-1:0]  p_w    [MaxTaps+1];
  logic signed [ProdW-1:0] prod_w [MaxTaps+1];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    if (tap_count_q == '0) begin
      m_now = MW'(1);
    end else if (32'(tap_count_q) > 32'(MaxTaps)) begin
      m_now = MW'(MaxTaps);
    end else begin
      m_now = MW'(tap_count_q);
    end
  end

  always_comb begin
    for (int j = 0; j < MaxTaps; j++) begin
      tap_we[j] = in_acc && (opcode_i == OP_LOAD) && (32'(tap_index_i) == j);
      keep[j]   = (32'(j + 1) < 32'(m_q));
    end
  end

  assign p_w[MaxTaps]    = '0;
  assign prod_w[MaxTaps] = '0;

  for (genvar g = 0; g < MaxTaps; g++) begin : g_cell
    flc_cell #(
      .AccW(AccW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tap_we_i   (tap_we[g]),
      .keep_i     (keep[g]),
      .value_i    (value_i),
      .p_next_i   (p_w[g+1]),
      .prod_next_i(prod_w[g+1]),
      .p_o        (p_w[g]),
      .prod_o     (prod_w[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    m_d        = m_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    y_d        = y_q;
    ctrl       = '0;
    emit       = '0;
    emit_value = y_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (opcode_i == OP_SAMPLE)) begin
          ctrl.mul_en = 1'b1;
          m_d         = m_now;
          last_d      = last_sample_i;
          state_d     = ST_ACC;
        end
      end
      ST_ACC: begin
        y_d           = p_w[0] + AccW'(prod_w[0]);
        ctrl.shift_en = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (free) begin
          emit.valid = 1'b1;
          emit.last  = last_q && (m_q == MW'(1));
          cnt_d      = '0;
          state_d    = (last_q && (m_q != MW'(1))) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        emit_value = p_w[0];
        if (free) begin
          emit.valid    = 1'b1;
          emit.last     = (cnt_q == m_q - MW'(2));
          ctrl.flush_en = 1'b1;
          cnt_d         = cnt_q + MW'(1);
          if (emit.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= TapCountReset;
      m_q         <= MW'(1);
      cnt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  flc_out #(
    .AccW(AccW)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .emit_i          (emit),
    .emit_value_i    (emit_value),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .peak_magnitude_o(peak_magnitude_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the full linear convolution block

typedef struct {
  logic signed [flc_pkg::ResultW-1:0] value;
  logic [flc_pkg::ResultW-1:0]        peak;
  logic                               last;
} conv_out_t;

class conv_scoreboard;
  longint    kernel [flc_pkg::TapsDefault];
  longint    partial [flc_pkg::TapsDefault];
  longint    peak_mag;
  int        taps_used;
  int        errors;
  conv_out_t expected_q[$];

  function new();
    foreach (kernel[i]) kernel[i] = 0;
    foreach (partial[i]) partial[i] = 0;
    peak_mag  = 0;
    taps_used = 1;
    errors    = 0;
  endfunction

  function void set_tap_count(logic [flc_pkg::CfgW-1:0] count);
    if (count == 0) begin
      taps_used = 1;
    end else if (count > flc_pkg::TapsDefault) begin
      taps_used = flc_pkg::TapsDefault;
    end else begin
      taps_used = int'(count);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // saturate, track the peak magnitude and queue one output word
  function void push_output(longint sum, logic last);
    conv_out_t item;
    longint    sum_hi;
    longint    sum_lo;
    longint    mag;
    sum_hi = (longint'(1) <<< (flc_pkg::ResultW - 1)) - 1;
    sum_lo = -(longint'(1) <<< (flc_pkg::ResultW - 1));
    if (sum > sum_hi) sum = sum_hi;
    if (sum < sum_lo) sum = sum_lo;
    mag = (sum < 0) ? -sum : sum;
    if (mag > peak_mag) peak_mag = mag;
    item.value = sum[flc_pkg::ResultW-1:0];
    item.peak  = peak_mag[flc_pkg::ResultW-1:0];
    item.last  = last;
    expected_q = {expected_q, item};
  endfunction

  function void note_input(logic op, logic [flc_pkg::TapIdxW-1:0] idx,
                           logic signed [flc_pkg::ValueW-1:0] v, logic last);
    longint x;
    longint y;
    x = longint'(v);
    if (op == flc_pkg::OP_LOAD) begin
      kernel[idx] = x;
      return;
    end
    // transposed form: output now, then shift the pending sums down
    y = partial[0] + kernel[0] * x;
    for (int j = 0; j < flc_pkg::TapsDefault; j++) begin
      if (j + 1 < taps_used) begin
        partial[j] = partial[j + 1] + kernel[j + 1] * x;
      end else begin
        partial[j] = 0;
      end
    end
    push_output(y, last && taps_used == 1);
    if (last) begin
      for (int j = 0; j + 1 < taps_used; j++) begin
        push_output(partial[j], j + 2 == taps_used);
      end
      foreach (partial[i]) partial[i] = 0;
      peak_mag = 0;
    end
  endfunction

  function void check_result(logic signed [flc_pkg::ResultW-1:0] value,
                             logic [flc_pkg::ResultW-1:0] peak, logic last);
    conv_out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result value %0d peak %0d last %0b",
               $time, value, peak, last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (value !== want.value) begin
      $display("%0t: result_value expected %0d actual %0d", $time, want.value, value);
      errors++;
    end
    if (peak !== want.peak) begin
      $display("%0t: peak_magnitude expected %0d actual %0d", $time, want.peak, peak);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: last_result expected %0b actual %0b", $time, want.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  import flc_pkg::*;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      opcode_i;
  logic [TapIdxW-1:0]        tap_index_i;
  logic signed [ValueW-1:0]  value_i;
  logic                      last_sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [ResultW-1:0] result_value_o;
  logic [ResultW-1:0]        peak_magnitude_o;
  logic                      last_result_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgW-1:0]           cfg_data_i;

  conv_scoreboard sb = new();
  int             hold_asked = 0;
  bit             hold_on = 1'b0;

  full_linear_convolution u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .tap_index_i      (tap_index_i),
    .value_i          (value_i),
    .last_sample_i    (last_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o),
    .peak_magnitude_o (peak_magnitude_o),
    .last_result_o    (last_result_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(result_value_o, peak_magnitude_o, last_result_o);
    end
  end

  // output side: random back-pressure, plus one long hold on request
  initial begin
    int unsigned on_len;
    int unsigned off_len;
    int unsigned pick;
    int          hold_done;
    hold_done = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_done < hold_asked) begin
        hold_done++;
        out_ready_i <= 1'b0;
        hold_on = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_on = 1'b0;
      end else begin
        on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        pick = $urandom_range(0, 99);
        if (pick < 50) off_len = 0;
        else if (pick < 90) off_len = $urandom_range(1, 3);
        else off_len = $urandom_range(15, 50);
        out_ready_i <= 1'b1;
        repeat (on_len) @(posedge clk_i);
        if (off_len != 0) begin
          out_ready_i <= 1'b0;
          repeat (off_len) @(posedge clk_i);
        end
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return 16'sh7fff;
    if (pick < 4) return 16'sh8000;
    if (pick == 4) return '0;
    return ValueW'($urandom);
  endfunction

  // valid is left high after acceptance so back-to-back words need no toggle
  task automatic send_word(input logic op, input logic [TapIdxW-1:0] idx,
                           input logic signed [ValueW-1:0] v, input logic last);
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    tap_index_i   <= idx;
    value_i       <= v;
    last_sample_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, idx, v, last);
  endtask

  task automatic sender_pause(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected word is out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tap_count(input logic [CfgW-1:0] count);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_tap_count(count);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int          tap_choices [8];
    int unsigned random_sent;
    int unsigned phase;
    int unsigned seq_len;
    int unsigned count;
    bit          quiet;
    tap_choices   = '{1, 2, 32, 0, 63, 17, 33, 3};
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    opcode_i      <= OP_LOAD;
    tap_index_i   <= '0;
    value_i       <= '0;
    last_sample_i <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= TapCountReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full kernel of most negative taps, then a run that saturates at the peak
    write_tap_count(CfgW'(TapsDefault));
    for (int i = 0; i < TapsDefault; i++) begin
      send_word(OP_LOAD, TapIdxW'(i), 16'sh8000, i[0]);
    end
    for (int i = 0; i < TapsDefault; i++) begin
      send_word(OP_SAMPLE, '0, 16'sh8000, i == TapsDefault - 1);
    end

    // single tap: the last sample carries the final-output flag itself
    write_tap_count(CfgW'(1));
    send_word(OP_LOAD, '0, 16'sh7fff, 1'b1);
    send_word(OP_SAMPLE, '1, 16'sh7fff, 1'b0);
    send_word(OP_SAMPLE, '0, 16'sh8000, 1'b1);

    // zero count acts as one, oversized count acts as the maximum
    write_tap_count(CfgW'(0));
    send_word(OP_SAMPLE, '0, '0, 1'b1);
    write_tap_count('1);
    send_word(OP_LOAD, TapIdxW'(5), 16'sh7fff, 1'b0);
    send_word(OP_SAMPLE, '0, 16'sh7fff, 1'b1);

    // shrink the tap count in the middle of a sequence
    write_tap_count(CfgW'(4));
    send_word(OP_SAMPLE, '0, 16'sh7fff, 1'b0);
    send_word(OP_SAMPLE, '0, 16'sh8000, 1'b0);
    send_word(OP_SAMPLE, '0, 16'sh1234, 1'b0);
    write_tap_count(CfgW'(2));
    send_word(OP_SAMPLE, '0, 16'sh7fff, 1'b1);

    random_sent = 0;
    phase       = 0;
    while (random_sent < 300) begin
      if (phase < 8) begin
        count = tap_choices[phase];
      end else if ($urandom_range(0, 1) == 0) begin
        count = $urandom_range(1, 8);
      end else begin
        count = $urandom_range(0, 63);
      end
      write_tap_count(CfgW'(count));
      // block fills while the output side holds off
      if (phase == 1) begin
        hold_asked++;
        wait (hold_on);
      end
      quiet   = ($urandom_range(0, 3) == 0);
      seq_len = $urandom_range(10, 50);
      repeat (seq_len) begin
        if (!quiet) sender_pause(sender_gap());
        if ($urandom_range(0, 99) < 15) begin
          send_word(OP_LOAD, TapIdxW'($urandom), pick_value(), 1'($urandom));
        end else begin
          send_word(OP_SAMPLE, TapIdxW'($urandom), pick_value(),
                    $urandom_range(0, 7) == 0);
        end
        random_sent++;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== full_linear_convolution.f =====
design/flc_pkg.sv
design/flc_cell.sv
design/flc_out.sv
design/full_linear_convolution.sv
verif/tb.sv
